/* hdl/primitive_assembler_macros.svh */
// Assertion macros shared by the primitive assembler modules.
// Depends on a clock named i_clk and an active-low reset named i_rst_n in the using module.
`ifndef PRIMITIVE_ASSEMBLER_MACROS_SVH
`define PRIMITIVE_ASSEMBLER_MACROS_SVH

`define PA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define PA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/pa_pkg.sv */
// Package for the primitive assembler: topology codes, result kinds and the job record.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package pa_pkg;

    localparam int WORD_W  = 32;
    localparam int MODE_W  = 3;
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = QPTR_W + 1;

    typedef enum logic [2:0] {
        MODE_POINTS    = 3'd0,
        MODE_LINES     = 3'd1,
        MODE_LINE_STRIP = 3'd2,
        MODE_TRIANGLES = 3'd3,
        MODE_TRI_STRIP = 3'd4,
        MODE_TRI_FAN   = 3'd5
    } t_mode;

    typedef enum logic [1:0] {
        KIND_POINT    = 2'd0,
        KIND_LINE     = 2'd1,
        KIND_TRIANGLE = 2'd2
    } t_kind;

    typedef struct packed {
        logic [WORD_W-1:0] x;
        logic [WORD_W-1:0] y;
        logic [WORD_W-1:0] c;
    } t_vert;

    // One classified vertex: the results it causes, in emission order.
    typedef struct packed {
        t_vert       v0;
        t_vert       v1;
        t_vert       v2;
        logic [1:0]  cnt;
        t_kind       kind;
        logic [1:0]  corner0;
    } t_job;

endpackage

/* hdl/primitive_assembler.sv */
// Top level of the primitive assembler: front end, job queue and back end.
// Depends on pa_pkg, pa_front, pa_queue and pa_back.
//
//  channel   direction  handshake               payload
//  vertex    in         i_valid / o_stall       i_vert_x, i_vert_y, i_vert_color, i_end_of_batch
//  result    out        o_valid / i_stall       o_out_x ... o_last_of_run
//  config    in         i_cfg_valid / o_cfg_ready  i_cfg_data (topology)
//
// A vertex is classified in the cycle it is accepted; its zero to three results leave the
// single output register at one per cycle unless i_stall holds them; triangle strips and fans
// give three per vertex, points and triangle lists one. The output port is the limiting unit.
// A four-entry job queue lets vertices enter while results are stalled.
// Reset is synchronous; it clears the topology to points and all assembly state.
`timescale 1ns / 1ps

module primitive_assembler (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [pa_pkg::MODE_W-1:0] i_cfg_data,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [pa_pkg::WORD_W-1:0] i_vert_x,
    input  logic [pa_pkg::WORD_W-1:0] i_vert_y,
    input  logic [pa_pkg::WORD_W-1:0] i_vert_color,
    input  logic                      i_end_of_batch,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [pa_pkg::WORD_W-1:0] o_out_x,
    output logic [pa_pkg::WORD_W-1:0] o_out_y,
    output logic [pa_pkg::WORD_W-1:0] o_out_color,
    output logic [1:0]                o_prim_kind,
    output logic [1:0]                o_corner,
    output logic                      o_last_of_run
);
    import pa_pkg::*;

    logic  accept, push, pop, full, empty;
    t_vert vert;
    t_job  job, head;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = full;
    assign accept      = i_valid && !full;
    assign vert        = '{x: i_vert_x, y: i_vert_y, c: i_vert_color};

    pa_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_data     (i_cfg_data),
        .i_accept       (accept),
        .i_vert         (vert),
        .i_end_of_batch (i_end_of_batch),
        .o_push         (push),
        .o_job          (job)
    );

    pa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    pa_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (empty),
        .i_head        (head),
        .o_pop         (pop),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_out_x       (o_out_x),
        .o_out_y       (o_out_y),
        .o_out_color   (o_out_color),
        .o_prim_kind   (o_prim_kind),
        .o_corner      (o_corner),
        .o_last_of_run (o_last_of_run)
    );

endmodule

/* hdl/pa_front.sv */
// Front end of the primitive assembler: holds the topology register and assembly state,
// accepts vertices and turns each into a job of zero to three results. Depends on pa_pkg.
`timescale 1ns / 1ps

module pa_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [pa_pkg::MODE_W-1:0] i_cfg_data,
    input  logic                  i_accept,
    input  pa_pkg::t_vert         i_vert,
    input  logic                  i_end_of_batch,
    output logic                  o_push,
    output pa_pkg::t_job          o_job
);
    import pa_pkg::*;

    logic [MODE_W-1:0] r_mode;
    t_vert             r_first, r_older, r_newer;
    logic [1:0]        r_seen, r_slot;
    logic              r_odd;

    t_vert      n_first, n_older, n_newer;
    logic [1:0] n_seen, n_slot;
    logic       n_odd;
    t_job       job;

    always_comb begin
        job         = '0;
        job.v0      = i_vert;
        job.kind    = KIND_POINT;
        n_first     = r_first;
        n_older     = r_older;
        n_newer     = r_newer;
        n_seen      = r_seen;
        n_slot      = r_slot;
        n_odd       = r_odd;
        unique case (t_mode'(r_mode))
            MODE_POINTS: begin
                job.cnt = 2'd1;
            end
            MODE_LINES: begin
                if (r_slot == 2'd0) begin
                    n_slot = 2'd1;
                end else begin
                    job.cnt  = 2'd2;
                    job.kind = KIND_LINE;
                    job.v0   = r_newer;
                    job.v1   = i_vert;
                    job.v1.c = r_newer.c;
                    n_slot   = 2'd0;
                end
            end
            MODE_LINE_STRIP: begin
                if (r_seen != 2'd0) begin
                    job.cnt  = 2'd2;
                    job.kind = KIND_LINE;
                    job.v0   = r_newer;
                    job.v1   = i_vert;
                    job.v1.c = r_newer.c;
                end
            end
            MODE_TRIANGLES: begin
                job.cnt     = 2'd1;
                job.kind    = KIND_TRIANGLE;
                job.corner0 = r_slot;
                n_slot      = (r_slot == 2'd2) ? 2'd0 : r_slot + 2'd1;
            end
            MODE_TRI_STRIP: begin
                if (r_seen == 2'd2) begin
                    job.cnt  = 2'd3;
                    job.kind = KIND_TRIANGLE;
                    job.v0   = r_odd ? r_newer : r_older;
                    job.v1   = r_odd ? r_older : r_newer;
                    job.v2   = i_vert;
                    n_odd    = ~r_odd;
                end
            end
            MODE_TRI_FAN: begin
                if (r_seen == 2'd2) begin
                    job.cnt  = 2'd3;
                    job.kind = KIND_TRIANGLE;
                    job.v0   = r_first;
                    job.v1   = r_newer;
                    job.v2   = i_vert;
                end
            end
            default: begin
                job.cnt = 2'd0;
            end
        endcase
        if (r_mode <= MODE_W'(MODE_TRI_FAN)) begin
            if (r_seen == 2'd0) begin
                n_first = i_vert;
            end
            n_older = r_newer;
            n_newer = i_vert;
            if (r_seen != 2'd2) begin
                n_seen = r_seen + 2'd1;
            end
        end
    end

    assign o_job  = job;
    assign o_push = i_accept && (job.cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_W'(MODE_POINTS);
            r_seen <= '0;
            r_slot <= '0;
            r_odd  <= 1'b0;
            r_first <= '0;
            r_older <= '0;
            r_newer <= '0;
        end else if (i_cfg_valid) begin
            r_mode <= i_cfg_data;
            r_seen <= '0;
            r_slot <= '0;
            r_odd  <= 1'b0;
            r_first <= '0;
            r_older <= '0;
            r_newer <= '0;
        end else if (i_accept) begin
            if (i_end_of_batch) begin
                r_seen <= '0;
                r_slot <= '0;
                r_odd  <= 1'b0;
                r_first <= '0;
                r_older <= '0;
                r_newer <= '0;
            end else begin
                r_seen <= n_seen;
                r_slot <= n_slot;
                r_odd  <= n_odd;
                r_first <= n_first;
                r_older <= n_older;
                r_newer <= n_newer;
            end
        end
    end

endmodule

/* hdl/pa_queue.sv */
// Short job queue between the front end and the back end of the primitive assembler.
// Depends on pa_pkg and the assertion macros.
`timescale 1ns / 1ps
`include "primitive_assembler_macros.svh"

module pa_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  pa_pkg::t_job  i_job,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output pa_pkg::t_job  o_head
);
    import pa_pkg::*;

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    `PA_ASSERT_NOW(a_no_push_full, i_push, !o_full, "job pushed into a full queue")
    `PA_ASSERT_NOW(a_no_pop_empty, i_pop, !o_empty, "job popped from an empty queue")
    `PA_ASSERT_NOW(a_count_bound, 1'b1, r_count <= QCNT_W'(QDEPTH), "queue count out of range")

endmodule

/* hdl/pa_back.sv */
// Back end of the primitive assembler: walks the head job one result per cycle, unless the
// output stalls, into a registered output stage. Depends on pa_pkg and the assertion macros.
`timescale 1ns / 1ps
`include "primitive_assembler_macros.svh"

module pa_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_empty,
    input  pa_pkg::t_job              i_head,
    output logic                      o_pop,
    input  logic                      i_stall,
    output logic                      o_valid,
    output logic [pa_pkg::WORD_W-1:0] o_out_x,
    output logic [pa_pkg::WORD_W-1:0] o_out_y,
    output logic [pa_pkg::WORD_W-1:0] o_out_color,
    output logic [1:0]                o_prim_kind,
    output logic [1:0]                o_corner,
    output logic                      o_last_of_run
);
    import pa_pkg::*;

    logic [1:0] r_idx;
    logic       r_valid;
    t_vert      r_vert;
    logic [1:0] r_kind, r_corner;
    logic       r_last;

    logic  advance, fire, last;
    t_vert sel;

    assign advance = !r_valid || !i_stall;
    assign fire    = advance && !i_empty;
    assign last    = (r_idx == i_head.cnt - 2'd1);
    assign o_pop   = fire && last;

    always_comb begin
        unique case (r_idx)
            2'd0:    sel = i_head.v0;
            2'd1:    sel = i_head.v1;
            default: sel = i_head.v2;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (fire) begin
                r_valid <= 1'b1;
                r_idx   <= last ? 2'd0 : r_idx + 2'd1;
            end else if (advance) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_vert   <= sel;
            r_kind   <= i_head.kind;
            r_corner <= i_head.corner0 + r_idx;
            r_last   <= last;
        end
    end

    assign o_valid       = r_valid;
    assign o_out_x       = r_vert.x;
    assign o_out_y       = r_vert.y;
    assign o_out_color   = r_vert.c;
    assign o_prim_kind   = r_kind;
    assign o_corner      = r_corner;
    assign o_last_of_run = r_last;

    `PA_ASSERT_NOW(a_idx_in_job, !i_empty, r_idx < i_head.cnt, "result index beyond its job")
    `PA_ASSERT_NOW(a_job_nonzero, !i_empty, i_head.cnt != 2'd0, "empty job in the queue")
    `PA_ASSERT_NEXT(a_idx_restart, o_pop, r_idx == 2'd0, "index not restarted after a job")

endmodule

/* dv/tb_primitive_assembler.sv */
// Self-checking testbench for primitive_assembler: vertex batches go through every topology
// and the emitted corners are compared with a built-in predictor. Depends on pa_pkg and the RTL.
`timescale 1ns / 1ps

module tb_primitive_assembler;
    import pa_pkg::*;

    localparam logic [2:0] MODE_UNUSED6 = 3'd6;
    localparam logic [2:0] MODE_UNUSED7 = 3'd7;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE_TIME  = 16;
    localparam int RANDOM_VERTS = 200;

    typedef struct {
        logic [WORD_W-1:0] x;
        logic [WORD_W-1:0] y;
        logic [WORD_W-1:0] c;
        t_kind             kind;
        logic [1:0]        corner;
        logic              last;
    } t_emitted;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [MODE_W-1:0] cfg_data = '0;
    logic              vtx_valid = 1'b0;
    logic              vtx_stall;
    logic [WORD_W-1:0] vtx_x = '0;
    logic [WORD_W-1:0] vtx_y = '0;
    logic [WORD_W-1:0] vtx_color = '0;
    logic              vtx_eob = 1'b0;
    logic              res_valid;
    logic              res_stall = 1'b0;
    logic [WORD_W-1:0] res_x;
    logic [WORD_W-1:0] res_y;
    logic [WORD_W-1:0] res_color;
    logic [1:0]        res_kind;
    logic [1:0]        res_corner;
    logic              res_last;

    // Predictor state.
    logic [2:0] topo;
    t_vert      fan_center;
    t_vert      prev2;
    t_vert      prev1;
    logic [1:0] seen;
    logic       odd_tri;
    logic [1:0] slot;

    t_emitted pending_corners[$];
    t_emitted want;
    int       errors = 0;
    int       verts_sent = 0;
    int       corners_checked = 0;
    int       topo_writes = 0;
    int       cycle_count = 0;
    int       stall_hold = 0;
    bit       stall_on = 1'b0;
    bit       gaps_on = 1'b0;

    primitive_assembler uut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_data     (cfg_data),
        .i_valid        (vtx_valid),
        .o_stall        (vtx_stall),
        .i_vert_x       (vtx_x),
        .i_vert_y       (vtx_y),
        .i_vert_color   (vtx_color),
        .i_end_of_batch (vtx_eob),
        .o_valid        (res_valid),
        .i_stall        (res_stall),
        .o_out_x        (res_x),
        .o_out_y        (res_y),
        .o_out_color    (res_color),
        .o_prim_kind    (res_kind),
        .o_corner       (res_corner),
        .o_last_of_run  (res_last)
    );

    always #1 clk = ~clk;

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: no progress after %0d cycles", $time, CYCLE_LIMIT);
            $display("FAIL primitive_assembler");
            $finish;
        end
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 25);
    endfunction

    always @(negedge clk) begin
        if (!stall_on) begin
            res_stall <= 1'b0;
            stall_hold = 0;
        end else if (stall_hold > 0) begin
            stall_hold--;
        end else begin
            stall_hold = idle_len();
            if (stall_hold == 0) begin
                res_stall <= 1'b0;
                stall_hold = $urandom_range(0, 2);
            end else begin
                res_stall <= 1'b1;
                stall_hold--;
            end
        end
    end

    function automatic logic [WORD_W-1:0] random_word();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return $urandom;
    endfunction

    function automatic t_vert random_vertex();
        t_vert v;
        v.x = random_word();
        v.y = random_word();
        v.c = random_word();
        return v;
    endfunction

    function automatic t_emitted make_corner(t_vert v, logic [WORD_W-1:0] col, t_kind k,
                                             logic [1:0] pos);
        t_emitted e;
        e.x = v.x;
        e.y = v.y;
        e.c = col;
        e.kind = k;
        e.corner = pos;
        e.last = 1'b0;
        return e;
    endfunction

    task automatic reset_assembly();
        fan_center = '0;
        prev2 = '0;
        prev1 = '0;
        seen = '0;
        odd_tri = 1'b0;
        slot = '0;
    endtask

    // Regroups one accepted vertex into the corners it completes.
    task automatic assemble_vertex(input t_vert cur, input logic eob);
        t_emitted batch[$];
        case (topo)
            MODE_POINTS: batch.push_back(make_corner(cur, cur.c, KIND_POINT, 2'd0));
            MODE_LINES: begin
                if (slot == 2'd0) begin
                    slot = 2'd1;
                end else begin
                    batch.push_back(make_corner(prev1, prev1.c, KIND_LINE, 2'd0));
                    batch.push_back(make_corner(cur, prev1.c, KIND_LINE, 2'd1));
                    slot = 2'd0;
                end
            end
            MODE_LINE_STRIP: begin
                if (seen >= 2'd1) begin
                    batch.push_back(make_corner(prev1, prev1.c, KIND_LINE, 2'd0));
                    batch.push_back(make_corner(cur, prev1.c, KIND_LINE, 2'd1));
                end
            end
            MODE_TRIANGLES: begin
                batch.push_back(make_corner(cur, cur.c, KIND_TRIANGLE, slot));
                slot = (slot == 2'd2) ? 2'd0 : slot + 2'd1;
            end
            MODE_TRI_STRIP: begin
                if (seen >= 2'd2) begin
                    if (!odd_tri) begin
                        batch.push_back(make_corner(prev2, prev2.c, KIND_TRIANGLE, 2'd0));
                        batch.push_back(make_corner(prev1, prev1.c, KIND_TRIANGLE, 2'd1));
                    end else begin
                        batch.push_back(make_corner(prev1, prev1.c, KIND_TRIANGLE, 2'd0));
                        batch.push_back(make_corner(prev2, prev2.c, KIND_TRIANGLE, 2'd1));
                    end
                    batch.push_back(make_corner(cur, cur.c, KIND_TRIANGLE, 2'd2));
                    odd_tri = ~odd_tri;
                end
            end
            MODE_TRI_FAN: begin
                if (seen >= 2'd2) begin
                    batch.push_back(make_corner(fan_center, fan_center.c, KIND_TRIANGLE, 2'd0));
                    batch.push_back(make_corner(prev1, prev1.c, KIND_TRIANGLE, 2'd1));
                    batch.push_back(make_corner(cur, cur.c, KIND_TRIANGLE, 2'd2));
                end
            end
            default: ;
        endcase
        if (topo <= MODE_TRI_FAN) begin
            if (seen == 2'd0) fan_center = cur;
            prev2 = prev1;
            prev1 = cur;
            if (seen < 2'd2) seen = seen + 2'd1;
        end
        if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
        foreach (batch[i]) pending_corners.push_back(batch[i]);
        if (eob) reset_assembly();
    endtask

    task automatic check_field(input string name, input logic [WORD_W-1:0] exp_val,
                               input logic [WORD_W-1:0] got_val);
        if (exp_val !== got_val) begin
            errors++;
            $display("%0t: %s expected %h got %h", $time, name, exp_val, got_val);
        end
    endtask

    always @(posedge clk) begin
        if (rst_n && res_valid && !res_stall) begin
            if (pending_corners.size() == 0) begin
                errors++;
                $display("%0t: unexpected result x=%h y=%h color=%h kind=%0d corner=%0d",
                         $time, res_x, res_y, res_color, res_kind, res_corner);
            end else begin
                want = pending_corners.pop_front();
                check_field("x", want.x, res_x);
                check_field("y", want.y, res_y);
                check_field("color", want.c, res_color);
                check_field("kind", want.kind, res_kind);
                check_field("corner", want.corner, res_corner);
                check_field("last_of_run", want.last, res_last);
                corners_checked++;
            end
        end
    end

    // Sends one vertex transaction and records its expected corners on acceptance.
    task automatic send_vertex(input t_vert v, input logic eob);
        int gap;
        gap = gaps_on ? idle_len() : 0;
        @(negedge clk);
        if (gap > 0) begin
            vtx_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        vtx_valid <= 1'b1;
        vtx_x <= v.x;
        vtx_y <= v.y;
        vtx_color <= v.c;
        vtx_eob <= eob;
        do @(posedge clk); while (vtx_stall);
        verts_sent++;
        assemble_vertex(v, eob);
    endtask

    task automatic drain();
        @(negedge clk);
        vtx_valid <= 1'b0;
        while (pending_corners.size() != 0) @(posedge clk);
    endtask

    task automatic set_topology(input logic [2:0] code);
        drain();
        repeat (SETTLE_TIME) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= code;
        do @(posedge clk); while (!cfg_ready);
        topo = code;
        reset_assembly();
        topo_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_batch(input int len, input logic close);
        for (int i = 0; i < len; i++)
            send_vertex(random_vertex(), (i == len - 1) ? close : 1'b0);
    endtask

    task automatic test_points_extremes();
        set_topology(MODE_POINTS);
        send_vertex('0, 1'b0);
        send_vertex('1, 1'b1);
    endtask

    task automatic test_line_pairs();
        set_topology(MODE_LINES);
        send_batch(3, 1'b1);
        set_topology(MODE_LINE_STRIP);
        send_batch(3, 1'b1);
    endtask

    task automatic test_triangle_lists();
        set_topology(MODE_TRIANGLES);
        send_batch(4, 1'b1);
    endtask

    task automatic test_strip_and_fan();
        set_topology(MODE_TRI_STRIP);
        send_batch(2, 1'b1);
        send_batch(4, 1'b1);
        set_topology(MODE_TRI_FAN);
        send_batch(4, 1'b1);
    endtask

    task automatic test_unused_modes();
        set_topology(MODE_UNUSED6);
        send_vertex(random_vertex(), 1'b1);
        set_topology(MODE_UNUSED7);
        send_vertex(random_vertex(), 1'b0);
    endtask

    // The sender waits for every pending corner mid-batch, then the fan continues.
    task automatic test_pressure();
        stall_on = 1'b1;
        gaps_on = 1'b0;
        set_topology(MODE_TRI_FAN);
        send_batch(4, 1'b0);
        drain();
        send_batch(3, 1'b1);
    endtask

    task automatic test_random_batches();
        int       counted;
        int       len;
        int       phases;
        int       r;
        logic [2:0] code;
        counted = 0;
        while (counted < RANDOM_VERTS) begin
            r = $urandom_range(0, 19);
            if (r == 0) code = MODE_UNUSED6;
            else if (r == 1) code = MODE_UNUSED7;
            else code = 3'($urandom_range(0, 5));
            stall_on = ($urandom_range(0, 3) != 0);
            gaps_on = ($urandom_range(0, 3) != 0);
            set_topology(code);
            phases = $urandom_range(1, 3);
            repeat (phases) begin
                len = $urandom_range(1, 10);
                for (int i = 0; i < len; i++) begin
                    if (i == len - 1)
                        send_vertex(random_vertex(), $urandom_range(0, 3) != 0);
                    else
                        send_vertex(random_vertex(), $urandom_range(0, 15) == 0);
                    if (code <= MODE_TRI_FAN) counted++;
                end
            end
        end
    endtask

    initial begin
        reset_assembly();
        topo = MODE_POINTS;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        test_points_extremes();
        test_line_pairs();
        test_triangle_lists();
        test_strip_and_fan();
        test_unused_modes();
        test_pressure();
        test_random_batches();
        drain();
        repeat (SETTLE_TIME) @(posedge clk);
        $display("Sent %0d vertices over %0d topology writes, all codes 0 to 7 included.",
                 verts_sent, topo_writes);
        $display("Checked %0d emitted corners with random gaps and output stalls.",
                 corners_checked);
        if (errors == 0)
            $display("PASS primitive_assembler");
        else
            $display("FAIL primitive_assembler");
        $finish;
    end

endmodule
